>>> rtl/trt_pkg.sv
`default_nettype none
package trt_pkg;

  localparam int MAX_SITES_DEF = 64;
  localparam int FERMIONIC_DEF = 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_W         = 7;
  localparam int IDX_W         = 3;
  localparam int WORD_W        = 64;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH        = 3'd0,
    REG_HEIGHT       = 3'd1,
    REG_STEP1_X      = 3'd2,
    REG_STEP1_Y      = 3'd3,
    REG_STEP2_X      = 3'd4,
    REG_STEP2_Y      = 3'd5,
    REG_COUNT_FIRST  = 3'd6,
    REG_COUNT_SECOND = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [6:0] width;
    logic [6:0] height;
    logic [5:0] step1_x;
    logic [5:0] step1_y;
    logic [5:0] step2_x;
    logic [5:0] step2_y;
    logic [6:0] count_first;
    logic [6:0] count_second;
  } cfg_t;

  // One classified item: word plus lattice data already cleaned up.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [6:0]        w;
    logic [6:0]        h;
    logic [6:0]        n;
    logic [5:0]        s1x;
    logic [5:0]        s1y;
    logic [5:0]        s2x;
    logic [5:0]        s2y;
    logic [6:0]        ca;
    logic [6:0]        cb;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/trt_queue.sv
`default_nettype none
module trt_queue #(
  parameter int DEPTH = trt_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire trt_pkg::item_t wr_item,
  input  wire logic          pop,
  output trt_pkg::item_t     rd_item,
  output logic               full,
  output logic               empty
);
  import trt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/trt_front.sv
`default_nettype none
module trt_front #(
  parameter int MAX_SITES = trt_pkg::MAX_SITES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire trt_pkg::cfg_t      cfg,
  input  wire logic [63:0]        basis_word,
  output logic                    busy,
  output logic                    push,
  output trt_pkg::item_t          item,
  input  wire logic               full
);
  import trt_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_REDUCE = 2'b10
  } fstate_t;

  fstate_t     state;
  logic [6:0]  w_c;
  logic [6:0]  h_c;
  logic [13:0] area;
  logic        reduced;

  assign w_c  = (cfg.width == '0) ? 7'd1 : cfg.width;
  assign h_c  = (cfg.height == '0) ? 7'd1 : cfg.height;
  assign area = 14'(w_c) * 14'(h_c);

  assign reduced = ({1'b0, item.s1x} < item.w) && ({1'b0, item.s2x} < item.w) &&
                   ({1'b0, item.s1y} < item.h) && ({1'b0, item.s2y} < item.h);

  assign busy = (state != F_IDLE);
  assign push = (state == F_REDUCE) && reduced && !full;

  function automatic logic [6:0] clamp_count(input logic [6:0] c);
    if (c == '0) begin
      return 7'd1;
    end else if (c > 7'd64) begin
      return 7'd64;
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      item.word <= basis_word;
      item.w    <= w_c;
      item.h    <= h_c;
      item.n    <= (area > 14'(MAX_SITES)) ? 7'(MAX_SITES) : area[6:0];
      item.s1x  <= cfg.step1_x;
      item.s1y  <= cfg.step1_y;
      item.s2x  <= cfg.step2_x;
      item.s2y  <= cfg.step2_y;
      item.ca   <= clamp_count(cfg.count_first);
      item.cb   <= clamp_count(cfg.count_second);
    end else if (state == F_REDUCE) begin
      // strip whole periods, one subtract per step component per cycle
      if ({1'b0, item.s1x} >= item.w) item.s1x <= item.s1x - item.w[5:0];
      if ({1'b0, item.s2x} >= item.w) item.s2x <= item.s2x - item.w[5:0];
      if ({1'b0, item.s1y} >= item.h) item.s1y <= item.s1y - item.h[5:0];
      if ({1'b0, item.s2y} >= item.h) item.s2y <= item.s2y - item.h[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) state <= F_REDUCE;
        end
        F_REDUCE: begin
          if (push) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/trt_back.sv
`default_nettype none
module trt_back #(
  parameter int FERMIONIC = trt_pkg::FERMIONIC_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire trt_pkg::item_t item,
  input  wire logic           empty,
  output logic                pop,
  output logic                done,
  output logic [63:0]         lowest_word,
  output logic [5:0]          shift_first,
  output logic [5:0]          shift_second,
  output logic                negative_sign,
  output logic [12:0]         self_count,
  output logic                is_lowest
);
  import trt_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t     state;
  item_t       cur;
  logic [5:0]  a, b, d, x, y;
  logic [6:0]  tx, ty, row_tx, row_ty;
  logic [63:0] t, used, lowest;
  logic        odd, best_odd;

  logic [6:0]  sx_w, sy_w;
  logic [7:0]  tx_sum, ty_sum, rx_sum, ry_sum;
  logic [6:0]  sx, sy, tx_step, ty_step, rx_step, ry_step;
  logic [5:0]  src6;
  logic [13:0] src;
  logic        occ, par_bit, last_site, last_b, last_a, below_word;
  logic [63:0] above, t_next, used_next;
  logic        odd_next;

  assign pop = (state == B_IDLE) && !empty;

  always_comb begin
    // wrap modulo 128 is exact here since the true source coordinate is below 128
    sx_w = (7'(x) >= tx) ? 7'(x) - tx : 7'(x) + cur.w - tx;
    sy_w = (7'(y) >= ty) ? 7'(y) - ty : 7'(y) + cur.h - ty;
    sx   = sx_w;
    sy   = sy_w;
    src  = 14'(sy) * 14'(cur.w) + 14'(sx);
    src6 = src[5:0];
    occ  = (src < 14'(cur.n)) && cur.word[src6];
    above     = ~((64'd2 << src6) - 64'd1);
    par_bit   = ^(used & above);
    t_next    = t | (64'(occ) << d);
    used_next = used | (64'(occ) << src6);
    odd_next  = odd ^ (occ & par_bit);
    last_site = ({1'b0, d} == cur.n - 7'd1);
    last_b    = ({1'b0, b} == cur.cb - 7'd1);
    last_a    = ({1'b0, a} == cur.ca - 7'd1);
    below_word = (t_next < cur.word);

    tx_sum  = 8'(tx) + 8'(cur.s2x);
    ty_sum  = 8'(ty) + 8'(cur.s2y);
    rx_sum  = 8'(row_tx) + 8'(cur.s1x);
    ry_sum  = 8'(row_ty) + 8'(cur.s1y);
    tx_step = (tx_sum >= 8'(cur.w)) ? 7'(tx_sum - 8'(cur.w)) : tx_sum[6:0];
    ty_step = (ty_sum >= 8'(cur.h)) ? 7'(ty_sum - 8'(cur.h)) : ty_sum[6:0];
    rx_step = (rx_sum >= 8'(cur.w)) ? 7'(rx_sum - 8'(cur.w)) : rx_sum[6:0];
    ry_step = (ry_sum >= 8'(cur.h)) ? 7'(ry_sum - 8'(cur.h)) : ry_sum[6:0];
  end

  assign lowest_word   = lowest;
  assign negative_sign = (FERMIONIC != 0) ? best_odd : 1'b0;

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      cur          <= item;
      lowest       <= item.word;
      shift_first  <= '0;
      shift_second <= '0;
      best_odd     <= 1'b0;
      self_count   <= '0;
      is_lowest    <= 1'b1;
      a <= '0; b <= '0; d <= '0; x <= '0; y <= '0;
      tx <= '0; ty <= '0; row_tx <= '0; row_ty <= '0;
      t <= '0; used <= '0; odd <= 1'b0;
    end else begin
      if (last_site) begin
        if (t_next == cur.word) self_count <= self_count + 13'd1;
        if (below_word) is_lowest <= 1'b0;
        if (t_next < lowest) begin
          lowest       <= t_next;
          shift_first  <= a;
          shift_second <= b;
          best_odd     <= odd_next;
        end
        t <= '0; used <= '0; odd <= 1'b0;
        d <= '0; x <= '0; y <= '0;
        if (last_b) begin
          b      <= '0;
          a      <= a + 6'd1;
          row_tx <= rx_step;
          row_ty <= ry_step;
          tx     <= rx_step;
          ty     <= ry_step;
        end else begin
          b  <= b + 6'd1;
          tx <= tx_step;
          ty <= ty_step;
        end
      end else begin
        t    <= t_next;
        used <= used_next;
        odd  <= odd_next;
        d    <= d + 6'd1;
        if ({1'b0, x} == cur.w - 7'd1) begin
          x <= '0;
          y <= y + 6'd1;
        end else begin
          x <= x + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!empty) state <= B_RUN;
        end
        B_RUN: begin
          if (last_site && last_b && last_a) begin
            state <= B_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/torus_translation_representative_unit.sv
// Flow: the front accepts a word and folds the step vectors into the lattice,
//   the back then sweeps n * count_first * count_second sites (n = sites in
//   use) after the queue hand-off; the result strobe done lasts one cycle.
// Throughput: one lattice site per cycle in the translation sweep.
// Reset: synchronous, active high; clears the queue and both controllers and
//   restores the register reset values. The result side has no stall.
`default_nettype none
module torus_translation_representative_unit #(
  parameter int MAX_SITES = trt_pkg::MAX_SITES_DEF,
  parameter int FERMIONIC = trt_pkg::FERMIONIC_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [trt_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [trt_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [63:0]                 basis_word,
  output logic                             done,
  output logic [63:0]                      lowest_word,
  output logic [5:0]                       shift_first,
  output logic [5:0]                       shift_second,
  output logic                             negative_sign,
  output logic [12:0]                      self_count,
  output logic                             is_lowest
);
  import trt_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t back_item;
  logic  push, pop, full, empty;

  // Configuration registers: write any time the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width        <= 7'd4;
      cfg.height       <= 7'd4;
      cfg.step1_x      <= 6'd1;
      cfg.step1_y      <= 6'd0;
      cfg.step2_x      <= 6'd0;
      cfg.step2_y      <= 6'd1;
      cfg.count_first  <= 7'd4;
      cfg.count_second <= 7'd4;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH:        cfg.width        <= cfg_data;
        REG_HEIGHT:       cfg.height       <= cfg_data;
        REG_STEP1_X:      cfg.step1_x      <= cfg_data[5:0];
        REG_STEP1_Y:      cfg.step1_y      <= cfg_data[5:0];
        REG_STEP2_X:      cfg.step2_x      <= cfg_data[5:0];
        REG_STEP2_Y:      cfg.step2_y      <= cfg_data[5:0];
        REG_COUNT_FIRST:  cfg.count_first  <= cfg_data;
        REG_COUNT_SECOND: cfg.count_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: take the word, clean up dimensions, counts and steps.
  trt_front #(.MAX_SITES(MAX_SITES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cfg        (cfg),
    .basis_word (basis_word),
    .busy       (busy),
    .push       (push),
    .item       (front_item),
    .full       (full)
  );

  // Short queue: lets the front take the next word while the sweep runs.
  trt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (back_item),
    .full    (full),
    .empty   (empty)
  );

  // Back: sweep translations site by site and track the smallest word.
  trt_back #(.FERMIONIC(FERMIONIC)) u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (back_item),
    .empty         (empty),
    .pop           (pop),
    .done          (done),
    .lowest_word   (lowest_word),
    .shift_first   (shift_first),
    .shift_second  (shift_second),
    .negative_sign (negative_sign),
    .self_count    (self_count),
    .is_lowest     (is_lowest)
  );

endmodule
`default_nettype wire

>>> rtl/trt_checker.sv
`default_nettype none
module trt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [5:0] shift_first,
  input wire logic [5:0] shift_second,
  input wire logic       negative_sign,
  input wire logic       is_lowest
);

  a_take_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");

  a_lowest_identity: assert property (@(posedge clk) disable iff (rst)
    done && is_lowest |-> shift_first == 6'd0 && shift_second == 6'd0 && !negative_sign)
    else $error("lowest word without identity translation");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !done) else $error("activity right after reset");

endmodule

bind torus_translation_representative_unit trt_checker u_chk (.*);
`default_nettype wire
